FILE: rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: event codes, register indexes
// and field widths. No dependencies.
package ps2md_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned NumEv   = 5;

  typedef enum logic [1:0] {
    EvDown  = 2'd0,
    EvUp    = 2'd1,
    EvMove  = 2'd2,
    EvWheel = 2'd3
  } event_kind_e;

  localparam logic [CfgIdxW-1:0] CfgSyncThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartWheel    = 2'd1;

  localparam logic [CountW-1:0] ThresholdReset = 4'd2;

  // Pending-event slots, in delivery order.
  localparam int unsigned SlotMove  = 3;
  localparam int unsigned SlotWheel = 4;

endpackage

FILE: rtl/ps2_mouse_packet_decoder_top.sv
// PS/2 mouse packet decoder, top level. Frames mouse bytes into 3- or 4-byte
// packets and emits button, move and wheel events. Depends on ps2md_pkg.
//
// A completed packet's events pass through the event queue into the output
// register. Throughput: one byte per cycle while no events are queued; a
// byte that completes a packet queues up to five events, which drain one per
// cycle unless the output stalls, so the next byte waits until the last of
// them moves into the output register. Asynchronous active-low reset clears
// all framing state and loads the defaults (threshold 2, three-byte mode).
module ps2_mouse_packet_decoder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Byte input channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ps2md_pkg::ByteW-1:0]      data_byte_i,
  // Event output channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       event_kind_o,
  output logic [1:0]                       button_number_o,
  output logic signed [8:0]                delta_x_o,
  output logic signed [9:0]                delta_y_o,
  output logic signed [7:0]                wheel_delta_o,
  output logic                             last_of_packet_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ps2md_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ps2md_pkg::CfgW-1:0]       cfg_data_i
);
  import ps2md_pkg::*;

  // Framing and configuration state.
  logic [CountW-1:0] thr_q, thr_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              wheel_q, wheel_d;
  logic [1:0]        pos_q, pos_d;
  logic [2:0]        prev_q, prev_d;
  logic [ByteW-1:0]  pkt_q [3];
  logic              pkt_we;

  // Queue of events produced by the last completed packet. Each bit of the
  // pending mask is one event slot: three buttons, move, wheel.
  logic [NumEv-1:0]  pend_q, pend_d;
  logic [2:0]        btn_q, btn_d;
  logic signed [8:0] dx_q, dx_d;
  logic signed [9:0] dy_q, dy_d;
  logic signed [7:0] wh_q, wh_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  event_kind_e       kind_q, kind_d;
  logic [1:0]        bnum_q, bnum_d;
  logic signed [8:0] ox_q, ox_d;
  logic signed [9:0] oy_q, oy_d;
  logic signed [7:0] ow_q, ow_d;
  logic              last_q, last_d;

  logic              in_fire, cfg_fire, out_load;
  logic              drop_hdr, complete;
  logic [NumEv-1:0]  sel, new_mask;
  logic [8:0]        x9, y9;
  logic [ByteW-1:0]  y_byte;
  logic [2:0]        buttons, changed;

  // The output register can take a new event when it is empty or being read.
  assign out_load = !out_valid_q || out_ready_i;

  // A new byte is taken only when the queue will be empty after this cycle,
  // so a completed packet always finds room for all of its events.
  assign in_ready_o  = (pend_q == '0) || ($onehot(pend_q) && out_load);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  // Lowest pending slot goes out first.
  assign sel = pend_q & (~pend_q + NumEv'(1));

  always_comb begin
    // A header byte must carry the sync bit; otherwise it is dropped.
    drop_hdr = (pos_q == 2'd0) && !data_byte_i[3];
    complete = !drop_hdr && (wheel_q ? (pos_q == 2'd3) : (pos_q == 2'd2));

    // In three-byte mode the Y byte is the current one; in wheel mode it was
    // stored and the current byte is the scroll amount.
    y_byte  = wheel_q ? pkt_q[2] : data_byte_i;
    x9      = {pkt_q[0][4], pkt_q[1]};
    y9      = {pkt_q[0][5], y_byte};
    buttons = pkt_q[0][2:0];
    changed = buttons ^ prev_q;

    dx_d = $signed(x9);
    dy_d = -$signed({y9[8], y9});
    wh_d = wheel_q ? $signed(data_byte_i) : 8'sd0;
    btn_d = buttons;

    new_mask = {wh_d != 8'sd0, (x9 != 9'd0) || (y9 != 9'd0), changed};

    thr_d   = thr_q;
    cnt_d   = cnt_q;
    wheel_d = wheel_q;
    pos_d   = pos_q;
    prev_d  = prev_q;
    pkt_we  = 1'b0;

    if (in_fire) begin
      if (drop_hdr) begin
        // Out-of-sync header: count down and flip the format at zero.
        cnt_d = cnt_q - CountW'(1);
        if (cnt_d == '0) begin
          wheel_d = !wheel_q;
          cnt_d   = thr_q;
        end
      end else if (complete) begin
        pos_d  = 2'd0;
        prev_d = buttons;
      end else begin
        pkt_we = 1'b1;
        pos_d  = pos_q + 2'd1;
      end
    end

    // Writes must come only while the block is idle; the block does not enforce it.
    if (cfg_fire) begin
      if (cfg_index_i == CfgSyncThreshold) begin
        thr_d = cfg_data_i;
        cnt_d = cfg_data_i;
      end else if (cfg_index_i == CfgStartWheel) begin
        wheel_d = cfg_data_i[0];
        pos_d   = 2'd0;
        cnt_d   = thr_q;
      end
    end
  end

  // Event queue drain into the output register.
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    bnum_d      = bnum_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    ow_d        = ow_q;
    last_d      = last_q;
    pend_d      = pend_q;

    if (out_load) begin
      out_valid_d = (pend_q != '0);
      pend_d      = pend_q & ~sel;
      last_d      = ((pend_q & ~sel) == '0);
      ox_d        = 9'sd0;
      oy_d        = 10'sd0;
      ow_d        = 8'sd0;
      bnum_d      = 2'd0;
      kind_d      = EvMove;
      if (sel[0]) begin
        kind_d = btn_q[0] ? EvDown : EvUp;
        bnum_d = 2'd1;
      end else if (sel[1]) begin
        kind_d = btn_q[1] ? EvDown : EvUp;
        bnum_d = 2'd2;
      end else if (sel[2]) begin
        kind_d = btn_q[2] ? EvDown : EvUp;
        bnum_d = 2'd3;
      end else if (sel[SlotMove]) begin
        kind_d = EvMove;
        ox_d   = dx_q;
        oy_d   = dy_q;
      end else if (sel[SlotWheel]) begin
        kind_d = EvWheel;
        ow_d   = wh_q;
      end
    end

    if (in_fire && complete) begin
      pend_d = new_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThresholdReset;
      cnt_q       <= ThresholdReset;
      wheel_q     <= 1'b0;
      pos_q       <= 2'd0;
      prev_q      <= 3'd0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      cnt_q       <= cnt_d;
      wheel_q     <= wheel_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (pkt_we) begin
      pkt_q[pos_q] <= data_byte_i;
    end
    if (in_fire && complete) begin
      btn_q <= btn_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      wh_q  <= wh_d;
    end
    kind_q <= kind_d;
    bnum_q <= bnum_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    ow_q   <= ow_d;
    last_q <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign button_number_o  = bnum_q;
  assign delta_x_o        = ox_q;
  assign delta_y_o        = oy_q;
  assign wheel_delta_o    = ow_q;
  assign last_of_packet_o = last_q;

  // A byte is only taken when at most one queued event remains.
  a_accept_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> $onehot0(pend_q))
    else $error("byte accepted while events still queued");

  // An event that is not the last one always has a successor queued.
  a_not_last_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (pend_q != '0))
    else $error("non-final event without queued successor");

  // Three-byte framing never reaches the fourth byte position.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wheel_q |-> (pos_q != 2'd3))
    else $error("byte position beyond three-byte packet");

endmodule
